/* hw/rtl/length_crc_frame_receiver_assert.svh */
// Assertion macros shared by the frame receiver modules.
// Each macro expects clk_i and rst_ni to be in scope.
`ifndef LENGTH_CRC_FRAME_RECEIVER_ASSERT_SVH
`define LENGTH_CRC_FRAME_RECEIVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCRC_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCRC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/lcrc_pkg.sv */
package lcrc_pkg;

  // Reflected CRC-32 polynomial and start value.
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Command queue between the parser and the CRC engine (power of two).
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Command kinds; the values match the result kind on the output port.
  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_END  = 1'b1
  } cmd_kind_e;

  // For a data command the byte sits in word[7:0]; for an end command word
  // holds the received CRC and length the header length.
  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] word;
    logic [31:0] length;
  } cmd_t;

  // One byte of the reflected CRC-32 update.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h00_0000, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* hw/rtl/lcrc_front.sv */
`include "length_crc_frame_receiver_assert.svh"

module lcrc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       rx_byte_i,
  input  logic             full_i,
  output logic             push_o,
  output lcrc_pkg::cmd_t   cmd_o
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_TRAILER = 2'd2;
  localparam logic [1:0] LAST_FIELD = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] len_q, len_d;
  logic [31:0] rem_q, rem_d;
  logic [23:0] trl_q, trl_d;
  logic [31:0] len_base;
  logic [1:0]  cnt_base;
  logic        accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    rem_d       = rem_q;
    trl_d       = trl_q;
    push_o      = 1'b0;
    cmd_o       = '0;
    cmd_o.kind  = lcrc_pkg::CMD_DATA;
    len_base    = (phase_q == PH_HEADER) ? len_q : 32'h0;
    cnt_base    = (phase_q == PH_HEADER) ? cnt_q : 2'd0;
    unique case (phase_q)
      PH_PAYLOAD: begin
        cmd_o.word = {24'h00_0000, rx_byte_i};
        push_o     = accept;
        if (accept) begin
          rem_d = rem_q - 32'd1;
          if (rem_q == 32'd1) begin
            phase_d = PH_TRAILER;
            cnt_d   = 2'd0;
          end
        end
      end
      PH_TRAILER: begin
        if (cnt_q != LAST_FIELD) begin
          if (accept) begin
            trl_d = {trl_q[15:0], rx_byte_i};
            cnt_d = cnt_q + 2'd1;
          end
        end else begin
          cmd_o.kind   = lcrc_pkg::CMD_END;
          cmd_o.word   = {trl_q, rx_byte_i};
          cmd_o.length = len_q;
          push_o       = accept;
          if (accept) begin
            phase_d = PH_HEADER;
            cnt_d   = 2'd0;
            len_d   = 32'h0;
            rem_d   = 32'h0;
            trl_d   = 24'h0;
          end
        end
      end
      default: begin
        // Header phase; the unused code restarts the header from scratch.
        if (accept) begin
          len_d = {len_base[23:0], rx_byte_i};
          if (cnt_base == LAST_FIELD) begin
            cnt_d   = 2'd0;
            rem_d   = len_d;
            trl_d   = 24'h0;
            phase_d = (len_d != 32'h0) ? PH_PAYLOAD : PH_TRAILER;
          end else begin
            cnt_d   = cnt_base + 2'd1;
            phase_d = PH_HEADER;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      cnt_q   <= 2'd0;
      len_q   <= 32'h0;
      rem_q   <= 32'h0;
      trl_q   <= 24'h0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      trl_q   <= trl_d;
    end
  end

  `LCRC_ASSERT_SAME(a_payload_count_nonzero, phase_q == PH_PAYLOAD, rem_q != 32'h0,
                    "payload phase entered with no bytes remaining")

endmodule

/* hw/rtl/lcrc_fifo.sv */
`include "length_crc_frame_receiver_assert.svh"

module lcrc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lcrc_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output lcrc_pkg::cmd_t head_o
);

  localparam int unsigned PTR_W = lcrc_pkg::FIFO_PTR_W;
  localparam int unsigned CNT_W = lcrc_pkg::FIFO_CNT_W;

  lcrc_pkg::cmd_t   mem_q [lcrc_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(lcrc_pkg::FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  `LCRC_ASSERT_SAME(a_no_push_when_full, full_o, !push_i,
                    "command pushed into a full queue")
  `LCRC_ASSERT_SAME(a_count_bounded, 1'b1, count_q <= CNT_W'(lcrc_pkg::FIFO_DEPTH),
                    "queue count beyond its depth")
  `LCRC_ASSERT_NEXT(a_count_grows, push_i && !full_o && !(pop_i && valid_o),
                    count_q == $past(count_q) + CNT_W'(1),
                    "queue count did not follow a lone push")

endmodule

/* hw/rtl/lcrc_back.sv */
`include "length_crc_frame_receiver_assert.svh"

module lcrc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  lcrc_pkg::cmd_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           result_kind_o,
  output logic [7:0]     payload_byte_o,
  output logic           frame_good_o,
  output logic [31:0]    frame_length_o
);

  logic                out_valid_q;
  logic [31:0]         crc_q;
  lcrc_pkg::cmd_kind_e kind_q;
  logic [7:0]          byte_q;
  logic                good_q;
  logic [31:0]         len_q;

  // The output register is free when empty or when its result is taken now.
  assign pop_o = valid_i && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      crc_q       <= lcrc_pkg::CRC_INIT;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        if (head_i.kind == lcrc_pkg::CMD_END) begin
          crc_q <= lcrc_pkg::CRC_INIT;
        end else begin
          crc_q <= lcrc_pkg::crc_byte(crc_q, head_i.word[7:0]);
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= head_i.kind;
      if (head_i.kind == lcrc_pkg::CMD_END) begin
        byte_q <= 8'h00;
        good_q <= (head_i.word == ~crc_q);
        len_q  <= head_i.length;
      end else begin
        byte_q <= head_i.word[7:0];
        good_q <= 1'b0;
        len_q  <= 32'h0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign payload_byte_o = byte_q;
  assign frame_good_o   = good_q;
  assign frame_length_o = len_q;

  `LCRC_ASSERT_SAME(a_end_has_no_byte, out_valid_q && kind_q == lcrc_pkg::CMD_END,
                    byte_q == 8'h00, "end-of-frame result carries a payload byte")
  `LCRC_ASSERT_NEXT(a_crc_restarts, pop_o && head_i.kind == lcrc_pkg::CMD_END,
                    crc_q == lcrc_pkg::CRC_INIT, "CRC not restarted after a frame end")

endmodule

/* hw/rtl/length_crc_frame_receiver.sv */
// Length-prefixed frame receiver with a CRC-32 trailer.
// Input channel: one link byte per transfer on rx_byte_i, qualified by
// in_valid_i and held off by in_stall_o. A frame is a 4-byte big-endian
// length, that many payload bytes, then the big-endian reflected CRC-32 of
// the payload. Output channel: one result per transfer, held off by
// out_stall_i. A payload byte gives a data result (kind 0); the last trailer
// byte gives an end result (kind 1) with the length and a CRC match flag.
// Header bytes and the first three trailer bytes give no result.
// Throughput is one byte per cycle while the queue is not full, set by the
// byte-wide CRC update in the back end. An accepted byte passes through the
// parser into the command queue, then through the CRC engine into the
// output register.
// Reset clears the parser to the header phase, empties the queue, drops any
// pending result and restarts the CRC. When the receiver stalls, the output
// register holds; the four-entry queue keeps absorbing bytes and in_stall_o
// rises only once it is full, so no byte is lost.
module length_crc_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        frame_good_o,
  output logic [31:0] frame_length_o
);

  // Commands from the parser to the CRC engine.
  lcrc_pkg::cmd_t cmd;
  lcrc_pkg::cmd_t head;
  logic           push;
  logic           full;
  logic           pop;
  logic           head_valid;

  // The parser tracks header, payload and trailer and emits a data command
  // for each payload byte and an end command for the last trailer byte.
  lcrc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  // The queue decouples the parser from a stalled output.
  lcrc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  // The CRC engine runs the CRC over payload bytes, checks it at frame end
  // and owns the output register.
  lcrc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .payload_byte_o (payload_byte_o),
    .frame_good_o   (frame_good_o),
    .frame_length_o (frame_length_o)
  );

endmodule
